// File: design/prqk_pkg.sv
// Shared types, constants and result codes for the packet ring queue with keep-alive.
`timescale 1ns / 1ps
`default_nettype none
package prqk_pkg;

	localparam int QUEUE_DEPTH_DEF  = 128;
	localparam int PACKET_WIDTH_DEF = 64;

	localparam int WORD_W  = 64;
	localparam int CLOCK_W = 32;
	localparam int KIND_W  = 3;

	localparam logic [CLOCK_W-1:0] KEEPALIVE_RESET = 32'd400000;

	localparam logic [KIND_W-1:0] KIND_STORED    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_REJECTED  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_SENT      = 3'd2;
	localparam logic [KIND_W-1:0] KIND_KEEPALIVE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_IDLE      = 3'd4;

	localparam logic FUNC_ENQUEUE = 1'b0;
	localparam logic FUNC_SERVICE = 1'b1;

	typedef struct packed {
		logic               func;
		logic [WORD_W-1:0]  packet_word;
		logic [CLOCK_W-1:0] clock_now;
		logic               bank_one_full;
		logic               bank_two_full;
	} prqk_in_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [WORD_W-1:0] sent_word;
		logic              last;
	} prqk_out_t;

endpackage
`default_nettype wire

// File: design/prqk_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module prqk_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: design/prqk_ring.sv
// Ring index control, keep-alive timer and transaction sequencer around the slot memory.
`timescale 1ns / 1ps
`default_nettype none
module prqk_ring import prqk_pkg::*; #(
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
	parameter int PACKET_WIDTH = PACKET_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire prqk_in_t           in_data,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output prqk_out_t               res_data,
	input  wire logic [CLOCK_W-1:0] interval
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_ENQ  = 2'd1;
	localparam logic [1:0] S_BANK = 2'd2;
	localparam logic [1:0] S_DATA = 2'd3;

	function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] i);
		return (i == IDX_LAST) ? '0 : i + 1'b1;
	endfunction

	logic [1:0]         state_q;
	logic               bank_q;
	prqk_in_t           item_q;
	logic [IDX_W-1:0]   rd_q;
	logic [IDX_W-1:0]   wr_q;
	logic [CLOCK_W-1:0] last_send_q;

	logic               ram_we;
	logic               ram_re;
	logic [PACKET_WIDTH-1:0] ram_rdata;

	logic               ring_full;
	logic               ring_busy;
	logic               bank_full;
	logic [CLOCK_W-1:0] elapsed;
	logic               ka_due;
	logic               res_fire;

	assign ring_full = (next_index(wr_q) == rd_q);
	assign ring_busy = (rd_q != wr_q);
	assign bank_full = bank_q ? item_q.bank_two_full : item_q.bank_one_full;
	// Wrapping difference: a clock that rolled over still yields the true gap.
	assign elapsed   = item_q.clock_now - last_send_q;
	assign ka_due    = (elapsed > interval);
	assign res_fire  = res_valid && res_ready;

	assign in_ready = (state_q == S_IDLE);
	assign ram_we   = (state_q == S_ENQ) && res_ready && !ring_full;
	assign ram_re   = (state_q == S_BANK) && !bank_full && ring_busy;

	always_comb begin
		res_valid          = 1'b0;
		res_data.kind      = KIND_IDLE;
		res_data.sent_word = '0;
		res_data.last      = bank_q;
		unique case (state_q)
			S_ENQ: begin
				res_valid     = 1'b1;
				res_data.kind = ring_full ? KIND_REJECTED : KIND_STORED;
				res_data.last = 1'b1;
			end
			S_BANK: begin
				res_valid = !ram_re;
				if (!bank_full && ka_due) begin
					res_data.kind = KIND_KEEPALIVE;
				end
			end
			S_DATA: begin
				res_valid          = 1'b1;
				res_data.kind      = KIND_SENT;
				res_data.sent_word = WORD_W'(ram_rdata);
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bank_q      <= 1'b0;
			rd_q        <= '0;
			wr_q        <= '0;
			last_send_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						bank_q  <= 1'b0;
						state_q <= (in_data.func == FUNC_SERVICE) ? S_BANK : S_ENQ;
					end
				end
				S_ENQ: begin
					if (res_ready) begin
						if (!ring_full) begin
							wr_q <= next_index(wr_q);
						end
						state_q <= S_IDLE;
					end
				end
				S_BANK: begin
					if (ram_re) begin
						state_q <= S_DATA;
					end else if (res_fire) begin
						if (!bank_full && ka_due) begin
							last_send_q <= item_q.clock_now;
						end
						bank_q  <= 1'b1;
						state_q <= bank_q ? S_IDLE : S_BANK;
					end
				end
				S_DATA: begin
					if (res_fire) begin
						rd_q        <= next_index(rd_q);
						last_send_q <= item_q.clock_now;
						bank_q      <= 1'b1;
						state_q     <= bank_q ? S_IDLE : S_BANK;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_data;
		end
	end

	prqk_ram #(
		.WIDTH(PACKET_WIDTH),
		.DEPTH(QUEUE_DEPTH)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_q),
		.wdata(item_q.packet_word[PACKET_WIDTH-1:0]),
		.re   (ram_re),
		.raddr(rd_q),
		.rdata(ram_rdata)
	);

endmodule
`default_nettype wire

// File: design/packet_ring_queue_keepalive_top.sv
// Top level of the packet ring queue with keep-alive: interval register and output register.
`timescale 1ns / 1ps
`default_nettype none
// Outgoing packet ring of QUEUE_DEPTH slots (one always empty) with a keep-alive timer.
// Items are taken one at a time. An enqueue transaction is first accepted, and then
// fullness is checked and the slot memory written. A service transaction is accepted,
// then decided bank by bank, with an extra read step for each bank that sends a packet,
// because the slot memory read is registered. Results pass through an output register,
// so a result may wait there while the ring works on the next step; a stalled output
// holds the ring at its next result. interval_q resets to 400000.
module packet_ring_queue_keepalive_top import prqk_pkg::*; #(
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
	parameter int PACKET_WIDTH = PACKET_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire prqk_in_t           in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output prqk_out_t               out_data,
	input  wire logic               cfg_we,
	input  wire logic [CLOCK_W-1:0] cfg_wdata
);

	logic [CLOCK_W-1:0] interval_q;
	logic               out_valid_q;
	prqk_out_t          out_q;

	logic               res_valid;
	logic               res_ready;
	prqk_out_t          res_data;

	assign res_ready = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q  <= KEEPALIVE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				interval_q <= cfg_wdata;
			end
			if (res_ready) begin
				out_valid_q <= res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res_data;
		end
	end

	prqk_ring #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.PACKET_WIDTH(PACKET_WIDTH)
	) u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data (res_data),
		.interval (interval_q)
	);

endmodule
`default_nettype wire

// File: design/prqk_checker.sv
// Port-level checker for the packet ring queue with keep-alive, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module prqk_checker import prqk_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_ready,
	input wire prqk_in_t  in_data,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire prqk_out_t out_data
);

	// A stalled result must hold.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Only a sent packet carries a word.
	a_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.kind != KIND_SENT) |-> (out_data.sent_word == '0))
		else $error("nonzero word on a result that sent no packet");

	// An enqueue has a single result, so it is always the last one.
	a_enq_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.kind == KIND_STORED || out_data.kind == KIND_REJECTED)
		|-> out_data.last)
		else $error("enqueue result without last");

	// Items are worked one at a time: after an accepted transaction the input closes.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted on consecutive cycles");

	// Kind codes stop at bank skipped.
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.kind <= KIND_IDLE))
		else $error("result kind out of range");

endmodule

bind packet_ring_queue_keepalive_top prqk_checker u_prqk_checker (.*);
`default_nettype wire
